[hdl/ddq_pkg.sv]
package ddq_pkg;

  localparam int NUM_W      = 31;
  localparam int POS_W      = 4;
  localparam int VAL_W      = 7;
  localparam int DIG_W      = 4;
  // 2^31-1 has ten decimal digits
  localparam int DEC_DIGITS = 10;
  localparam int BCD_W      = DEC_DIGITS * DIG_W;
  localparam int DIG_IDX_W  = $clog2(DEC_DIGITS);
  localparam int CNT_W      = $clog2(DEC_DIGITS + 1);
  localparam int STEP_W     = $clog2(NUM_W);
  localparam int MAX_DIGITS_DEF = 10;

  typedef enum logic [1:0] {
    OP_COUNT = 2'd0,
    OP_NTH   = 2'd1,
    OP_SUM   = 2'd2,
    OP_PAL   = 2'd3
  } ddq_op_t;

  typedef struct packed {
    ddq_op_t            opcode;
    logic [NUM_W-1:0]   number;
    logic [POS_W-1:0]   position;
  } ddq_in_t;

  typedef struct packed {
    logic [VAL_W-1:0]   value;
    logic               is_palindrome;
    logic               bad_position;
  } ddq_out_t;

  typedef struct packed {
    logic                 load;
    logic                 conv;
    logic                 scan;
    logic                 rev;
    logic                 finish;
    logic [DIG_IDX_W-1:0] idx;
  } ddq_cmd_t;

  typedef struct packed {
    logic [CNT_W-1:0] cnt;
  } ddq_stat_t;

endpackage

[hdl/ddq_ctrl.sv]
module ddq_ctrl
  import ddq_pkg::*;
#(
  parameter int MAX_DIGITS = MAX_DIGITS_DEF
) (
  input  logic      clk,
  input  logic      rst_n,
  input  logic      start,
  output logic      busy,
  input  ddq_stat_t stat,
  output ddq_cmd_t  cmd
);

  // digits actually examined
  localparam int LIM = (MAX_DIGITS < DEC_DIGITS) ? MAX_DIGITS : DEC_DIGITS;

  typedef enum logic [2:0] {
    S_IDLE,
    S_CONV,
    S_SCAN,
    S_REV,
    S_DONE
  } state_t;

  state_t            state_r;
  logic [STEP_W-1:0] step_r;
  logic              rev_last;

  assign rev_last = (stat.cnt == '0) ||
                    (step_r == STEP_W'(stat.cnt) - STEP_W'(1));

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
      step_r  <= '0;
    end else begin
      case (state_r)
        S_IDLE: begin
          step_r <= '0;
          if (start) state_r <= S_CONV;
        end
        S_CONV: begin
          if (step_r == STEP_W'(NUM_W - 1)) begin
            state_r <= S_SCAN;
            step_r  <= '0;
          end else begin
            step_r <= step_r + STEP_W'(1);
          end
        end
        S_SCAN: begin
          if (step_r == STEP_W'(LIM - 1)) begin
            state_r <= S_REV;
            step_r  <= '0;
          end else begin
            step_r <= step_r + STEP_W'(1);
          end
        end
        S_REV: begin
          if (rev_last) begin
            state_r <= S_DONE;
            step_r  <= '0;
          end else begin
            step_r <= step_r + STEP_W'(1);
          end
        end
        S_DONE: begin
          state_r <= S_IDLE;
        end
        default: begin
          state_r <= S_IDLE;
        end
      endcase
    end
  end

  always_comb begin
    cmd        = '0;
    cmd.load   = (state_r == S_IDLE) && start;
    cmd.conv   = (state_r == S_CONV);
    cmd.scan   = (state_r == S_SCAN);
    cmd.rev    = (state_r == S_REV) && (stat.cnt != '0);
    cmd.finish = (state_r == S_DONE);
    cmd.idx    = step_r[DIG_IDX_W-1:0];
  end

  assign busy = (state_r != S_IDLE);

endmodule

[hdl/ddq_datapath.sv]
module ddq_datapath
  import ddq_pkg::*;
(
  input  logic      clk,
  input  logic      rst_n,
  input  ddq_in_t   in_data,
  input  ddq_cmd_t  cmd,
  output ddq_stat_t stat,
  output logic      out_valid,
  output ddq_out_t  out_data
);

  ddq_op_t                            op_r;
  logic [POS_W-1:0]                   pos_r;
  logic [NUM_W-1:0]                   bin_r;
  logic [DEC_DIGITS-1:0][DIG_W-1:0]   bcd_r;
  logic [DEC_DIGITS-1:0][DIG_W-1:0]   rev_r;
  logic [CNT_W-1:0]                   cnt_r;
  logic [VAL_W-1:0]                   sum_r;
  logic [DIG_W-1:0]                   nth_r;
  logic                               out_valid_r;
  ddq_out_t                           out_data_r;

  logic [DEC_DIGITS-1:0][DIG_W-1:0]   adj;
  logic [BCD_W-1:0]                   adj_bits;
  logic [DEC_DIGITS-1:0][DIG_W-1:0]   bcd_nxt;
  logic [BCD_W-1:0]                   bcd_bits;
  logic [DEC_DIGITS-1:0]              nz_from;
  logic [DEC_DIGITS-1:0][DIG_W-1:0]   masked;
  logic [DIG_W-1:0]                   dig;
  logic                               bad;
  ddq_out_t                           res_nxt;

  // shift-add-3: fix up digits >= 5, then shift in the next binary bit
  always_comb begin
    for (int j = 0; j < DEC_DIGITS; j++) begin
      adj[j] = (bcd_r[j] >= DIG_W'(5)) ? bcd_r[j] + DIG_W'(3) : bcd_r[j];
    end
    adj_bits = adj;
    bcd_nxt  = {adj_bits[BCD_W-2:0], bin_r[NUM_W-1]};
  end

  assign dig = bcd_r[cmd.idx];

  // a digit position is seen while any digit at or above it is nonzero;
  // the scan length caps the count at the digit limit
  assign bcd_bits = bcd_r;

  always_comb begin
    for (int j = 0; j < DEC_DIGITS; j++) begin
      nz_from[j] = |(bcd_bits >> (j * DIG_W));
    end
  end

  always_comb begin
    for (int j = 0; j < DEC_DIGITS; j++) begin
      masked[j] = (CNT_W'(j) < cnt_r) ? bcd_r[j] : '0;
    end
  end

  always_comb begin
    bad     = (pos_r == '0) || (pos_r > POS_W'(cnt_r));
    res_nxt = '0;
    case (op_r)
      OP_COUNT: res_nxt.value = VAL_W'(cnt_r);
      OP_NTH: begin
        res_nxt.bad_position = bad;
        res_nxt.value        = bad ? '0 : VAL_W'(nth_r);
      end
      OP_SUM:   res_nxt.value = sum_r;
      OP_PAL:   res_nxt.is_palindrome = (rev_r == masked);
      default:  res_nxt = '0;
    endcase
  end

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      op_r  <= in_data.opcode;
      pos_r <= in_data.position;
      bin_r <= in_data.number;
      bcd_r <= '0;
      rev_r <= '0;
      cnt_r <= '0;
      sum_r <= '0;
      nth_r <= '0;
    end
    if (cmd.conv) begin
      bcd_r <= bcd_nxt;
      bin_r <= {bin_r[NUM_W-2:0], 1'b0};
    end
    if (cmd.scan) begin
      sum_r <= sum_r + VAL_W'(dig);
      if (nz_from[cmd.idx]) cnt_r <= CNT_W'(cmd.idx) + CNT_W'(1);
      if ((pos_r != '0) && ((pos_r - POS_W'(1)) == POS_W'(cmd.idx))) nth_r <= dig;
    end
    if (cmd.rev) begin
      rev_r <= {rev_r[DEC_DIGITS-2:0], dig};
    end
    if (cmd.finish) out_data_r <= res_nxt;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else begin
      out_valid_r <= cmd.finish;
    end
  end

  assign stat.cnt  = cnt_r;
  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

endmodule

[hdl/decimal_digit_query_unit_core.sv]
// Decimal digit query unit: one query per transfer, one result strobe per query.
// Steps: bit-serial binary to BCD conversion of all 31 bits, a scan of
// min(MAX_DIGITS,10) digits, a reverse pass over max(count,1) digits, a finish step.
// The next transfer is taken in the strobe cycle; no query is taken while busy,
// and the receiver cannot stall.
// Reset: synchronous active-low rst_n returns the controller to idle, no strobe.
module decimal_digit_query_unit_core
  import ddq_pkg::*;
#(
  parameter int MAX_DIGITS = MAX_DIGITS_DEF
) (
  input  logic     clk,
  input  logic     rst_n,
  input  logic     start,
  output logic     busy,
  input  ddq_in_t  in_data,
  output logic     out_valid,
  output ddq_out_t out_data
);

  ddq_cmd_t  cmd;
  ddq_stat_t stat;

  // Controller sequences: load -> convert (shift-add-3) -> scan digits for
  // count, sum and the selected digit -> rebuild the significant digits in
  // reverse order -> finish, which registers the answer and pulses out_valid.
  ddq_ctrl #(
    .MAX_DIGITS(MAX_DIGITS)
  ) u_ctrl (
    .clk   (clk),
    .rst_n (rst_n),
    .start (start),
    .busy  (busy),
    .stat  (stat),
    .cmd   (cmd)
  );

  // Datapath holds the operands, the BCD word, the running count and sum,
  // the reversed digits and the result register.
  ddq_datapath u_dp (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_data   (in_data),
    .cmd       (cmd),
    .stat      (stat),
    .out_valid (out_valid),
    .out_data  (out_data)
  );

`ifndef SYNTHESIS
  a_strobe_single: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |=> !out_valid)
    else $error("result strobe longer than one cycle");

  a_start_busy: assert property (@(posedge clk) disable iff (!rst_n)
    (start && !busy) |=> busy)
    else $error("accepted transfer did not raise busy");

  a_strobe_idle: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> !busy)
    else $error("result strobe while still busy");

  a_bad_clean: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && out_data.bad_position) |->
      (out_data.value == '0 && !out_data.is_palindrome))
    else $error("bad position with nonzero payload");

  a_pal_clean: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && out_data.is_palindrome) |-> (out_data.value == '0))
    else $error("palindrome result with nonzero value");
`endif

endmodule

[verif/testbench.sv]
`timescale 1ns / 100ps

module testbench;
  import ddq_pkg::*;

  // Digit limit the unit is built with; the predictor honors the same limit.
  localparam int TB_MAX_DIGITS = MAX_DIGITS_DEF;
  localparam int RANDOM_QUERIES = 500;
  // Watchdog bound on a quiet spell: covers one full query plus random idle cycles.
  localparam int STALL_LIMIT = 1000;
  localparam int DRAIN_CYCLES = 60;
  localparam int DIRECTED_ROWS = 24;

  logic     clk;
  logic     rst_n;
  logic     start;
  logic     busy;
  ddq_in_t  in_data;
  logic     out_valid;
  ddq_out_t out_data;

  // One directed query; answer is typed in only when known is set.
  typedef struct packed {
    ddq_in_t  query;
    logic     known;
    ddq_out_t answer;
  } query_row_t;

  ddq_out_t pending_answers[$];
  int       mismatch_count;
  int       answer_count;
  int       stall_cycles;

  // Extremes, every opcode, bad positions, zero, the tenth digit.
  query_row_t directed_rows [DIRECTED_ROWS] = '{
    '{'{OP_COUNT, 31'd0,          4'd0},  1'b1, '{7'd0,  1'b0, 1'b0}},
    '{'{OP_COUNT, 31'd2147483647, 4'd15}, 1'b1, '{7'd10, 1'b0, 1'b0}},
    '{'{OP_COUNT, 31'd999999999,  4'd0},  1'b1, '{7'd9,  1'b0, 1'b0}},
    '{'{OP_COUNT, 31'd1000000000, 4'd0},  1'b1, '{7'd10, 1'b0, 1'b0}},
    '{'{OP_SUM,   31'd0,          4'd0},  1'b1, '{7'd0,  1'b0, 1'b0}},
    '{'{OP_SUM,   31'd2147483647, 4'd0},  1'b1, '{7'd46, 1'b0, 1'b0}},
    '{'{OP_SUM,   31'd1999999999, 4'd0},  1'b1, '{7'd82, 1'b0, 1'b0}},
    '{'{OP_PAL,   31'd0,          4'd0},  1'b1, '{7'd0,  1'b1, 1'b0}},
    '{'{OP_PAL,   31'd2147483647, 4'd0},  1'b1, '{7'd0,  1'b0, 1'b0}},
    '{'{OP_PAL,   31'd7,          4'd0},  1'b1, '{7'd0,  1'b1, 1'b0}},
    '{'{OP_PAL,   31'd1234554321, 4'd0},  1'b1, '{7'd0,  1'b1, 1'b0}},
    '{'{OP_PAL,   31'd12321,      4'd3},  1'b0, '{7'd0,  1'b0, 1'b0}},
    '{'{OP_PAL,   31'd12340,      4'd1},  1'b0, '{7'd0,  1'b0, 1'b0}},
    '{'{OP_NTH,   31'd0,          4'd0},  1'b1, '{7'd0,  1'b0, 1'b1}},
    '{'{OP_NTH,   31'd0,          4'd1},  1'b1, '{7'd0,  1'b0, 1'b1}},
    '{'{OP_NTH,   31'd2147483647, 4'd0},  1'b1, '{7'd0,  1'b0, 1'b1}},
    '{'{OP_NTH,   31'd2147483647, 4'd1},  1'b1, '{7'd7,  1'b0, 1'b0}},
    '{'{OP_NTH,   31'd2147483647, 4'd10}, 1'b1, '{7'd2,  1'b0, 1'b0}},
    '{'{OP_NTH,   31'd2147483647, 4'd11}, 1'b1, '{7'd0,  1'b0, 1'b1}},
    '{'{OP_NTH,   31'd2147483647, 4'd15}, 1'b1, '{7'd0,  1'b0, 1'b1}},
    '{'{OP_NTH,   31'd1000000000, 4'd10}, 1'b1, '{7'd1,  1'b0, 1'b0}},
    '{'{OP_NTH,   31'd12345,      4'd6},  1'b1, '{7'd0,  1'b0, 1'b1}},
    '{'{OP_NTH,   31'd98765,      4'd3},  1'b0, '{7'd0,  1'b0, 1'b0}},
    '{'{OP_NTH,   31'd98765,      4'd5},  1'b0, '{7'd0,  1'b0, 1'b0}}
  };

  decimal_digit_query_unit_core #(
    .MAX_DIGITS(TB_MAX_DIGITS)
  ) dut (
    .clk(clk),
    .rst_n(rst_n),
    .start(start),
    .busy(busy),
    .in_data(in_data),
    .out_valid(out_valid),
    .out_data(out_data)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // Answer of one query: split into decimal digits (lowest first, capped at
  // the digit limit), then count, pick, sum or mirror-compare them.
  function automatic ddq_out_t answer_query(ddq_in_t q);
    logic [DIG_W-1:0] digs [DEC_DIGITS];
    int unsigned rest;
    int cnt;
    int sum;
    ddq_out_t ans;
    rest = 32'(q.number);
    cnt = 0;
    sum = 0;
    ans = '0;
    while (rest > 0 && cnt < TB_MAX_DIGITS && cnt < DEC_DIGITS) begin
      digs[cnt] = DIG_W'(rest % 10);
      rest = rest / 10;
      cnt++;
    end
    case (q.opcode)
      OP_COUNT: ans.value = VAL_W'(cnt);
      OP_NTH: begin
        if (q.position == 0 || int'(q.position) > cnt) ans.bad_position = 1'b1;
        else ans.value = VAL_W'(digs[q.position - POS_W'(1)]);
      end
      OP_SUM: begin
        for (int i = 0; i < cnt; i++) sum += int'(digs[i]);
        ans.value = VAL_W'(sum);
      end
      default: begin
        ans.is_palindrome = 1'b1;
        for (int i = 0; i < cnt / 2; i++)
          if (digs[i] != digs[cnt - 1 - i]) ans.is_palindrome = 1'b0;
      end
    endcase
    return ans;
  endfunction

  // Random query: numbers spread over every digit count, palindromes built on
  // purpose for the mirror test, positions mostly around the digit count.
  function automatic ddq_in_t make_query();
    ddq_in_t q;
    int unsigned lo;
    int unsigned num;
    int unsigned rest;
    int k;
    int half;
    int cnt;
    int d;
    int digs [DEC_DIGITS];
    q.opcode = ddq_op_t'($urandom_range(0, 3));
    k = $urandom_range(0, 10);
    if ($urandom_range(0, 9) == 0) begin
      num = $urandom & 32'h7FFF_FFFF;
    end else if (q.opcode == OP_PAL && k > 0 && $urandom_range(0, 1) == 1) begin
      half = (k + 1) / 2;
      for (int i = 0; i < half; i++) begin
        if (i == 0) d = (k == DEC_DIGITS) ? 1 : $urandom_range(1, 9);
        else d = $urandom_range(0, 9);
        digs[i] = d;
        digs[k - 1 - i] = d;
      end
      num = 0;
      for (int i = 0; i < k; i++) num = num * 10 + digs[i];
    end else if (k == 0) begin
      num = 0;
    end else if (k == DEC_DIGITS) begin
      num = $urandom_range(1000000000, 2147483647);
    end else begin
      lo = 1;
      repeat (k - 1) lo = lo * 10;
      num = $urandom_range(lo, lo * 10 - 1);
    end
    q.number = NUM_W'(num);
    rest = num;
    cnt = 0;
    while (rest > 0) begin
      rest = rest / 10;
      cnt++;
    end
    if ($urandom_range(0, 3) == 0) q.position = POS_W'($urandom_range(0, 15));
    else q.position = POS_W'($urandom_range(1, cnt + 1));
    return q;
  endfunction

  task automatic flag_mismatch(string what, int got, int want);
    $display("%0t: answer %0d %s: got %0d, want %0d", $realtime, answer_count, what,
             got, want);
    mismatch_count++;
  endtask

  // Hand one query over; start is dropped on random idle cycles, otherwise it
  // stays high until the transfer edge, where the expected answer is queued.
  task automatic send_query(ddq_in_t q, logic known, ddq_out_t answer, bit may_idle);
    in_data <= q;
    start <= !(may_idle && $urandom_range(0, 99) < 28);
    @(posedge clk);
    while (!(start && !busy)) begin
      start <= !(may_idle && $urandom_range(0, 99) < 28);
      @(posedge clk);
    end
    pending_answers.push_back(known ? answer : answer_query(q));
  endtask

  // Sender holds off until the unit has answered everything.
  task automatic wait_all_answered();
    start <= 1'b0;
    @(posedge clk);
    while (pending_answers.size() != 0) @(posedge clk);
  endtask

  // Result strobe: one cycle, compared with the oldest expected answer.
  always @(posedge clk) begin
    if (rst_n && out_valid) begin
      if (pending_answers.size() == 0) begin
        flag_mismatch("unexpected strobe, value", int'(out_data.value), -1);
      end else begin
        ddq_out_t want;
        want = pending_answers.pop_front();
        if (out_data.value !== want.value)
          flag_mismatch("value", int'(out_data.value), int'(want.value));
        if (out_data.is_palindrome !== want.is_palindrome)
          flag_mismatch("is_palindrome", int'(out_data.is_palindrome),
                        int'(want.is_palindrome));
        if (out_data.bad_position !== want.bad_position)
          flag_mismatch("bad_position", int'(out_data.bad_position),
                        int'(want.bad_position));
      end
      answer_count++;
    end
  end

  // Watchdog: any transfer in either direction resets the count.
  always @(posedge clk) begin
    if (!rst_n || (start && !busy) || out_valid) begin
      stall_cycles <= 0;
    end else begin
      stall_cycles <= stall_cycles + 1;
      if (stall_cycles >= STALL_LIMIT) begin
        $display("%0t: no transfer for %0d cycles", $realtime, STALL_LIMIT);
        $display("Regression FAIL");
        $finish;
      end
    end
  end

  initial begin
    clk = 1'b0;
    rst_n = 1'b0;
    start = 1'b0;
    in_data = '0;
    mismatch_count = 0;
    answer_count = 0;
    stall_cycles = 0;
    repeat (4) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    foreach (directed_rows[i])
      send_query(directed_rows[i].query, directed_rows[i].known,
                 directed_rows[i].answer, 1'b1);
    wait_all_answered();

    // Random part; a long run without gaps in the middle, two full drains.
    for (int n = 0; n < RANDOM_QUERIES; n++) begin
      if (n == 100 || n == 400) wait_all_answered();
      send_query(make_query(), 1'b0, '0, !(n >= 200 && n < 320));
    end

    wait_all_answered();
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (mismatch_count == 0) begin
      $display("Regression PASS");
    end else begin
      $display("Regression FAIL");
    end
    $finish;
  end

endmodule
